@@ src/bdq_pkg.sv @@
package bdq_pkg;

  // Operation codes carried in in_tuser
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

  localparam int DATA_W = 32;

  // Result word layout, lowest bit first
  localparam int FOUND_BIT = DATA_W;
  localparam int EMPTY_BIT = DATA_W + 1;
  localparam int FULL_BIT  = DATA_W + 2;
  localparam int OCC_LSB   = DATA_W + 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_search;
    logic empty;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

@@ src/bdq_ctrl.sv @@
module bdq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  bdq_pkg::sts_t sts,
  output bdq_pkg::cmd_t cmd
);
  import bdq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_search && !sts.empty) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ src/bdq_datapath.sv @@
module bdq_datapath #(
  parameter  int DEPTH = 16,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OW    = ((bdq_pkg::OCC_LSB + CW + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bdq_pkg::DATA_W-1:0]  in_tdata,
  input  logic [bdq_pkg::KIND_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OW-1:0]               out_tdata,
  input  bdq_pkg::cmd_t               cmd,
  output bdq_pkg::sts_t               sts
);
  import bdq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int PW = IW + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // ring index step: base + off, where off never reaches DEPTH
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [PW-1:0] sum;
    sum = {1'b0, base} + PW'(off);
    if (sum >= DEPTH_P) begin
      sum = sum - DEPTH_P;
    end
    return sum[IW-1:0];
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];

  logic [KIND_W-1:0] kind_r;
  logic [DATA_W-1:0] val_r;
  logic [IW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              full_flag_r, full_flag_nxt;
  logic              empty_flag_r, empty_flag_nxt;
  logic              pop_ok_r, pop_ok_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0]     scan_left_r, scan_left_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OW-1:0]     out_data_r, out_data_nxt;

  logic              we, re;
  logic [IW-1:0]     waddr, raddr;
  logic [IW-1:0]     front_dec;
  logic              is_push, is_pop, full, empty, hit;

  assign is_push   = (kind_r == KIND_PUSH_BACK) || (kind_r == KIND_PUSH_FRONT);
  assign is_pop    = (kind_r == KIND_POP_BACK) || (kind_r == KIND_POP_FRONT);
  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign hit       = cmp_vld_r && (rd_data_r == val_r);
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - IW'(1);

  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    full_flag_nxt  = full_flag_r;
    empty_flag_nxt = empty_flag_r;
    pop_ok_nxt     = pop_ok_r;
    found_nxt      = found_r;
    scan_ptr_nxt   = scan_ptr_r;
    scan_left_nxt  = scan_left_r;
    cmp_vld_nxt    = cmp_vld_r;
    we             = 1'b0;
    re             = 1'b0;
    waddr          = front_r;
    raddr          = front_r;

    if (cmd.exec) begin
      full_flag_nxt  = is_push && full;
      empty_flag_nxt = is_pop && empty;
      pop_ok_nxt     = is_pop && !empty;
      found_nxt      = 1'b0;
      scan_ptr_nxt   = front_r;
      scan_left_nxt  = count_r;
      cmp_vld_nxt    = 1'b0;
      case (kind_r)
        KIND_PUSH_BACK: begin
          if (!full) begin
            we        = 1'b1;
            waddr     = ring_add(front_r, count_r);
            count_nxt = count_r + CW'(1);
          end
        end
        KIND_PUSH_FRONT: begin
          if (!full) begin
            we        = 1'b1;
            waddr     = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        KIND_POP_BACK: begin
          if (!empty) begin
            re        = 1'b1;
            raddr     = ring_add(front_r, count_r - CW'(1));
            count_nxt = count_r - CW'(1);
          end
        end
        KIND_POP_FRONT: begin
          if (!empty) begin
            re        = 1'b1;
            raddr     = front_r;
            front_nxt = ring_add(front_r, CW'(1));
            count_nxt = count_r - CW'(1);
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end

    // walk: issue one read per cycle, compare the previous read
    if (cmd.scan) begin
      found_nxt = found_r || hit;
      if (scan_left_r != '0) begin
        re            = 1'b1;
        raddr         = scan_ptr_r;
        scan_ptr_nxt  = ring_add(scan_ptr_r, CW'(1));
        scan_left_nxt = scan_left_r - CW'(1);
        cmp_vld_nxt   = 1'b1;
      end else begin
        cmp_vld_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_data_nxt                    = '0;
    out_data_nxt[DATA_W-1:0]        = pop_ok_r ? rd_data_r : '0;
    out_data_nxt[FOUND_BIT]         = found_r;
    out_data_nxt[EMPTY_BIT]         = empty_flag_r;
    out_data_nxt[FULL_BIT]          = full_flag_r;
    out_data_nxt[OCC_LSB +: CW]     = count_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= val_r;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_tuser;
      val_r  <= in_tdata;
    end
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
    end
    full_flag_r  <= full_flag_nxt;
    empty_flag_r <= empty_flag_nxt;
    pop_ok_r     <= pop_ok_nxt;
    found_r      <= found_nxt;
    scan_ptr_r   <= scan_ptr_nxt;
    scan_left_r  <= scan_left_nxt;
    cmp_vld_r    <= cmp_vld_nxt;
  end

  assign sts.is_search = (kind_r == KIND_SEARCH);
  assign sts.empty     = empty;
  assign sts.scan_done = hit || (scan_left_r == '0);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ src/bounded_deque_with_search_core.sv @@
// Push, pop and status pass through the execute and finish states after the input transfer;
// a search also walks the entries, one per cycle, and stops early on a hit.
// A new operation is accepted once the last result reaches the output register;
// the single-port ring memory and the one-entry-per-cycle search walk set this pace.
// Reset (rst_n low, synchronous): queue emptied, front index zero, no result pending;
// memory contents are not cleared.
module bounded_deque_with_search_core #(
  parameter  int DEPTH = 16,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OW    = ((bdq_pkg::OCC_LSB + CW + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // operation input
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bdq_pkg::DATA_W-1:0] in_tdata,  // [31:0] operand_value
  input  logic [bdq_pkg::KIND_W-1:0] in_tuser,  // [2:0] kind
  // result output
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [31:0] result_value, [32] found, [33] was_empty, [34] was_full,
  // [35 +: CW] occupancy, zero fill above
  output logic [OW-1:0]              out_tdata
);
  import bdq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: accept one operation, run it, then hand the result to the
  // output register. The next transfer is taken while that result waits.
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: ring memory, front index and count, search walker and the
  // output register that holds a finished result until its transfer.
  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ src/bdq_checker.sv @@
module bdq_checker #(
  parameter  int DEPTH = 16,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OW    = ((bdq_pkg::OCC_LSB + CW + 7) / 8) * 8
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [OW-1:0] out_tdata
);
  import bdq_pkg::*;

  logic [CW-1:0]     occ;
  logic [DATA_W-1:0] res;

  assign occ = out_tdata[OCC_LSB +: CW];
  assign res = out_tdata[DATA_W-1:0];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FULL_BIT] |->
      occ == CW'(DEPTH) && !out_tdata[EMPTY_BIT] && !out_tdata[FOUND_BIT] && res == '0)
    else $error("refused push with inconsistent result");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[EMPTY_BIT] |-> occ == '0 && res == '0 && !out_tdata[FOUND_BIT])
    else $error("empty pop with inconsistent result");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FOUND_BIT] |-> occ != '0 && res == '0)
    else $error("search hit with no entries");

endmodule

bind bounded_deque_with_search_core bdq_checker #(
  .DEPTH (DEPTH)
) u_bdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ verif/bounded_deque_with_search_core_test.sv @@
`timescale 1ns / 1ps

module bounded_deque_with_search_core_test;
  import bdq_pkg::*;

  localparam int DEPTH = 16;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int OW    = ((OCC_LSB + OCC_W + 7) / 8) * 8;

  // Kinds that the package leaves unnamed: plain status and the two spare codes,
  // which the block must treat as status.
  localparam logic [KIND_W-1:0] KIND_STATUS     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RESERVED_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RESERVED_B = 3'd7;

  localparam int HOLD_CYCLES    = 300;
  localparam int ITEMS_PER_PASS = 410;
  localparam int TAIL_CYCLES    = 40;
  localparam int CYCLE_LIMIT    = 400000;

  typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              found;
    logic              was_empty;
    logic              was_full;
    logic [OCC_W-1:0]  occupancy;
  } deque_reply_t;

  // Tracks the deque contents transfer by transfer and holds the replies still owed.
  class deque_tracker;
    logic [DATA_W-1:0] ring[DEPTH];
    int                head;
    int                held;
    deque_reply_t      replies_due[$];
    int                mismatches;
    int                n_ops;
    int                n_refused;
    int                n_empty_pops;
    int                n_hits;

    function new();
      head = 0;
      held = 0;
      mismatches = 0;
      n_ops = 0;
      n_refused = 0;
      n_empty_pops = 0;
      n_hits = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    task report_mismatch(input string what, input logic [DATA_W-1:0] got,
                         input logic [DATA_W-1:0] want);
      mismatches++;
      $display("[%0t] mismatch, %s: got %h, want %h", $time, what, got, want);
    endtask

    task apply_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] operand);
      deque_reply_t r;
      int i;
      r.value = '0;
      r.found = 1'b0;
      r.was_empty = 1'b0;
      r.was_full = 1'b0;
      n_ops++;
      case (kind)
        KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
          if (held == DEPTH) begin
            r.was_full = 1'b1;
            n_refused++;
          end else if (kind == KIND_PUSH_BACK) begin
            ring[(head + held) % DEPTH] = operand;
            held++;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = operand;
            held++;
          end
        end
        KIND_POP_BACK, KIND_POP_FRONT: begin
          if (held == 0) begin
            r.was_empty = 1'b1;
            n_empty_pops++;
          end else if (kind == KIND_POP_BACK) begin
            r.value = ring[(head + held - 1) % DEPTH];
            held--;
          end else begin
            r.value = ring[head];
            head = (head + 1) % DEPTH;
            held--;
          end
        end
        KIND_SEARCH: begin
          for (i = 0; i < held; i++)
            if (ring[(head + i) % DEPTH] == operand) r.found = 1'b1;
          if (r.found) n_hits++;
        end
        default: ;
      endcase
      r.occupancy = held[OCC_W-1:0];
      replies_due = {replies_due, r};
    endtask

    task check_reply(input logic [OW-1:0] word);
      deque_reply_t want;
      if (replies_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", word[DATA_W-1:0], '0);
      end else begin
        want = replies_due[0];
        replies_due.delete(0);
        if (word[DATA_W-1:0] !== want.value)
          report_mismatch("result_value", word[DATA_W-1:0], want.value);
        if (word[FOUND_BIT] !== want.found)
          report_mismatch("found", word[FOUND_BIT], want.found);
        if (word[EMPTY_BIT] !== want.was_empty)
          report_mismatch("was_empty", word[EMPTY_BIT], want.was_empty);
        if (word[FULL_BIT] !== want.was_full)
          report_mismatch("was_full", word[FULL_BIT], want.was_full);
        if (word[OCC_LSB +: OCC_W] !== want.occupancy)
          report_mismatch("occupancy", word[OCC_LSB +: OCC_W], want.occupancy);
        if ((word >> (OCC_LSB + OCC_W)) !== '0)
          report_mismatch("zero fill", DATA_W'(word >> (OCC_LSB + OCC_W)), '0);
      end
    endtask
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic [KIND_W-1:0] in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OW-1:0]     out_tdata;

  deque_tracker tracker = new();

  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  bit          hold_request = 1'b0;
  int          hold_left    = 0;
  int          items_sent   = 0;
  int unsigned cycle_count  = 0;

  // Values seen recently; searches and pushes draw on them so hits and duplicates occur.
  logic [DATA_W-1:0] value_pool[8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                                       32'hAAAA_AAAA, 32'h0000_00FF};

  always #4 clk = ~clk;

  bounded_deque_with_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] operand_value
    .in_tuser   (in_tuser),    // [2:0] kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // [31:0] result_value, [32] found, [33] was_empty,
                               // [34] was_full, [39:35] occupancy
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, tracker.pending());
      $display("bounded_deque_with_search_core_test NOT OK");
      $finish;
    end
  end

  // Result side: check every transfer, then pick the next tready. A hold request
  // drops tready for a long stretch so the block backs up into its input.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_reply(out_tdata);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Reuse pooled values as often as drawing a fresh random word, which replaces a pool
  // entry; sometimes pick an extreme.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'hFFFF_FFFF;
        default: v = 32'h0000_0000;
      endcase
    end else if (r < 6) begin
      v = value_pool[$urandom_range(0, 7)];
    end else begin
      v = $urandom();
      value_pool[$urandom_range(0, 7)] = v;
    end
    return v;
  endfunction

  // Offer one operation, idling at random first, and hold it until the transfer.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] operand);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= operand;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.apply_op(kind, operand);
    items_sent++;
  endtask

  // Fill runs pushes until full and then a few refused pushes; drain pops until empty
  // and then a few empty pops; both sprinkle searches. Mixed is noise over every kind.
  task automatic run_burst(input burst_t mode);
    int left;
    logic [KIND_W-1:0] kind;
    if (mode == BURST_MIXED) begin
      repeat ($urandom_range(10, 30)) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: kind = KIND_PUSH_BACK;
          5, 6, 7, 8:    kind = KIND_PUSH_FRONT;
          9, 10, 11:     kind = KIND_POP_BACK;
          12, 13, 14:    kind = KIND_POP_FRONT;
          15, 16, 17:    kind = KIND_SEARCH;
          18:            kind = KIND_STATUS;
          default:       kind = $urandom_range(0, 1) ? KIND_RESERVED_A : KIND_RESERVED_B;
        endcase
        send_op(kind, pick_value());
      end
    end else begin
      left = $urandom_range(1, 3);
      while (left > 0) begin
        if ($urandom_range(0, 4) == 0) begin
          kind = KIND_SEARCH;
        end else if (mode == BURST_FILL) begin
          kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
          if (tracker.held == DEPTH) left--;
        end else begin
          kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
          if (tracker.held == 0) left--;
        end
        send_op(kind, pick_value());
      end
    end
  endtask

  initial begin
    int pass_no;
    int pass_start;
    bit pressed;
    bit paused;
    int r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-queue corner cases, the spare kinds, extreme values at both ends,
    // search hit and miss, and a pop that leaves the queue empty.
    send_op(KIND_POP_BACK,   32'h0000_0000);
    send_op(KIND_POP_FRONT,  32'hFFFF_FFFF);
    send_op(KIND_SEARCH,     32'h0000_0000);
    send_op(KIND_STATUS,     32'hFFFF_FFFF);
    send_op(KIND_RESERVED_A, 32'hFFFF_FFFF);
    send_op(KIND_RESERVED_B, 32'h8000_0000);
    send_op(KIND_PUSH_BACK,  32'h8000_0000);
    send_op(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
    send_op(KIND_PUSH_BACK,  32'hFFFF_FFFF);
    send_op(KIND_PUSH_BACK,  32'h0000_0000);
    send_op(KIND_SEARCH,     32'h8000_0000);
    send_op(KIND_SEARCH,     32'h7FFF_FFFF);
    send_op(KIND_SEARCH,     32'h0000_0001);
    send_op(KIND_STATUS,     32'h5555_5555);
    send_op(KIND_RESERVED_A, 32'h0000_0000);
    send_op(KIND_POP_FRONT,  32'h0000_0000);
    send_op(KIND_POP_BACK,   32'h0000_0000);
    send_op(KIND_POP_BACK,   32'h0000_0000);
    send_op(KIND_POP_FRONT,  32'h0000_0000);
    send_op(KIND_PUSH_FRONT, 32'h5555_5555);
    send_op(KIND_POP_BACK,   32'hAAAA_AAAA);
    send_op(KIND_POP_FRONT,  32'hAAAA_AAAA);

    // Random passes: sender-light/receiver-heavy idling, then the reverse, then none.
    for (pass_no = 0; pass_no < 3; pass_no++) begin
      case (pass_no)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 47;
        end
        1: begin
          tx_idle_pct = 47;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      pass_start = items_sent;
      pressed = 1'b0;
      paused = 1'b0;
      while (items_sent - pass_start < ITEMS_PER_PASS) begin
        if (!pressed && items_sent - pass_start >= 120) begin
          // Stall the result side and keep offering pushes until the input backs up.
          pressed = 1'b1;
          hold_request = 1'b1;
          run_burst(BURST_FILL);
        end else if (!paused && items_sent - pass_start >= 260) begin
          // Go quiet until every reply has come back.
          paused = 1'b1;
          in_tvalid <= 1'b0;
          while (tracker.pending() != 0) @(posedge clk);
        end else begin
          r = $urandom_range(0, 9);
          if (r < 3)      run_burst(BURST_FILL);
          else if (r < 6) run_burst(BURST_DRAIN);
          else            run_burst(BURST_MIXED);
        end
      end
    end

    in_tvalid <= 1'b0;
    rx_idle_pct = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d operations with %0d search hits, %0d refused pushes, %0d empty pops",
             tracker.n_ops, tracker.n_hits, tracker.n_refused, tracker.n_empty_pops);
    $display("under three idling mixes, a long result-side stall and a full drain pause");
    if (tracker.mismatches == 0) begin
      $display("bounded_deque_with_search_core_test OK");
    end else begin
      $display("bounded_deque_with_search_core_test NOT OK");
    end
    $finish;
  end

endmodule
